// ----- src/lavm_pkg.sv -----
// lavm_pkg: shared types and constants of the look-at view matrix core
// holds the transfer structs, the job record and the engine state codes
// no dependencies
package lavm_pkg;

    localparam int VAL_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int COL_W   = 2;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    localparam logic [COL_W-1:0] LAST_COL = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VAL_W-1:0] eye_x;
        logic signed [VAL_W-1:0] eye_y;
        logic signed [VAL_W-1:0] eye_z;
        logic signed [VAL_W-1:0] target_x;
        logic signed [VAL_W-1:0] target_y;
        logic signed [VAL_W-1:0] target_z;
    } cam_item_t;

    typedef struct packed {
        logic [COL_W-1:0]        column_index;
        logic signed [VAL_W-1:0] row0_value;
        logic signed [VAL_W-1:0] row1_value;
        logic signed [VAL_W-1:0] row2_value;
        logic signed [VAL_W-1:0] row3_value;
        logic                    last_column;
        logic                    degenerate;
        logic                    saturated;
    } col_item_t;

    // classified item as queued between front and back end
    typedef struct packed {
        logic signed [VAL_W-1:0]  eye_x;
        logic signed [VAL_W-1:0]  eye_y;
        logic signed [VAL_W-1:0]  eye_z;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic                     dzero;
    } job_t;

    // finished matrix terms handed to the column emitter
    typedef struct packed {
        logic signed [VAL_W-1:0] r0;
        logic signed [VAL_W-1:0] r1;
        logic signed [VAL_W-1:0] r2;
        logic signed [VAL_W-1:0] u0;
        logic signed [VAL_W-1:0] u1;
        logic signed [VAL_W-1:0] u2;
        logic signed [VAL_W-1:0] f0;
        logic signed [VAL_W-1:0] f1;
        logic signed [VAL_W-1:0] f2;
        logic signed [VAL_W-1:0] t0;
        logic signed [VAL_W-1:0] t1;
        logic signed [VAL_W-1:0] t2;
        logic                    degenerate;
        logic                    saturated;
    } mat_t;

    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_NORM,
        ENG_SQ,
        ENG_SQW,
        ENG_SQRT,
        ENG_DIV,
        ENG_MAC,
        ENG_MACW,
        ENG_DONE
    } eng_state_t;

    typedef enum logic [2:0] {
        DST_SUM,
        DST_U0,
        DST_U1,
        DST_U2,
        DST_T0,
        DST_T1,
        DST_T2
    } acc_dst_t;

endpackage

// ----- src/lavm_front.sv -----
// lavm_front: input side, forms target minus eye and flags a zero forward vector
// keeps classified items in a two-entry queue for the back end
// depends on lavm_pkg
module lavm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cam_valid,
    output logic                cam_ready,
    input  lavm_pkg::cam_item_t cam_item,
    output logic                job_valid,
    output lavm_pkg::job_t      job,
    input  logic                job_pop
);

    localparam int DW = lavm_pkg::DIFF_W;

    lavm_pkg::job_t                mem_reg [lavm_pkg::Q_DEPTH];
    logic [lavm_pkg::Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lavm_pkg::Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lavm_pkg::Q_CW-1:0]     fill_reg, fill_next;
    lavm_pkg::job_t                new_job;
    logic                          push;
    logic                          pop;

    // classify
    always_comb
    begin
        new_job.eye_x = cam_item.eye_x;
        new_job.eye_y = cam_item.eye_y;
        new_job.eye_z = cam_item.eye_z;
        new_job.dx    = DW'(cam_item.target_x) - DW'(cam_item.eye_x);
        new_job.dy    = DW'(cam_item.target_y) - DW'(cam_item.eye_y);
        new_job.dz    = DW'(cam_item.target_z) - DW'(cam_item.eye_z);
        new_job.dzero = (cam_item.target_x == cam_item.eye_x)
                     && (cam_item.target_y == cam_item.eye_y)
                     && (cam_item.target_z == cam_item.eye_z);
    end

    assign cam_ready = fill_reg != lavm_pkg::Q_CW'(lavm_pkg::Q_DEPTH);
    assign job_valid = fill_reg != '0;
    assign job       = mem_reg[rd_ptr_reg];
    assign push      = cam_valid && cam_ready;
    assign pop       = job_pop && job_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ----- src/lavm_engine.sv -----
// lavm_engine: back end, normalises f and r, builds u and the translation terms
// bit-serial square root and divider, one shared multiply-accumulate
// depends on lavm_pkg
module lavm_engine #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  lavm_pkg::job_t job,
    output logic           job_pop,
    output logic           mat_valid,
    input  logic           mat_ready,
    output lavm_pkg::mat_t mat
);

    localparam int VW        = lavm_pkg::VAL_W;
    localparam int DW        = lavm_pkg::DIFF_W;
    localparam int MAG_W     = DW;
    localparam int VEC_W     = FRAC_BITS + 2;
    localparam int MUL_W     = 33;
    localparam int ACC_W     = 2 * MUL_W;
    localparam int DIV_W     = MAG_W + FRAC_BITS;
    localparam int QW        = FRAC_BITS + 1;
    localparam int CNT_W     = ($clog2(FRAC_BITS + 1) > 5) ? $clog2(FRAC_BITS + 1) : 5;
    localparam int SQ_OPS    = 3;
    localparam int SQRT_STEPS = 32;
    localparam int MAC_OPS   = 12;
    localparam int LEN_W     = 32;

    lavm_pkg::eng_state_t state_reg, state_next;

    logic                     pass_reg, pass_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [VW-1:0]     eye_reg [3];
    logic signed [VW-1:0]     eye_next [3];
    logic [2:0]               sgn_reg, sgn_next;
    logic [MAG_W-1:0]         mg_reg [3];
    logic [MAG_W-1:0]         mg_next [3];
    logic                     zero_reg, zero_next;
    logic                     degen_reg, degen_next;
    logic                     sat_reg, sat_next;
    logic signed [VEC_W-1:0]  f_reg [3];
    logic signed [VEC_W-1:0]  f_next [3];
    logic signed [VEC_W-1:0]  r_reg [3];
    logic signed [VEC_W-1:0]  r_next [3];
    logic signed [VW-1:0]     u_reg [3];
    logic signed [VW-1:0]     u_next [3];
    logic signed [VW-1:0]     t_reg [3];
    logic signed [VW-1:0]     t_next [3];
    logic [63:0]              sq_n_reg, sq_n_next;
    logic [63:0]              sq_res_reg, sq_res_next;
    logic [63:0]              sq_bit_reg, sq_bit_next;
    logic [DIV_W-1:0]         rem_reg [3];
    logic [DIV_W-1:0]         rem_next [3];
    logic [DIV_W-1:0]         dsr_reg, dsr_next;
    logic [QW-1:0]            q_reg [3];
    logic [QW-1:0]            q_next [3];

    // multiply-accumulate pipeline
    logic                     issue;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     op_first, op_last;
    lavm_pkg::acc_dst_t       op_dest;
    logic signed [ACC_W-1:0]  prod_reg;
    logic                     p_vld_reg, p_first_reg, p_last_reg;
    lavm_pkg::acc_dst_t       p_dest_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     a_done_reg;
    lavm_pkg::acc_dst_t       a_dest_reg;

    logic                     wb_sum, wb_last;
    logic [ACC_W-1:0]         acc_mag, rnd;
    logic signed [ACC_W-1:0]  rs, tv;
    logic signed [VW-1:0]     clamp_v;
    logic                     clamp_hit;

    logic                     any_high, any_top;
    logic [64:0]              sq_trial;
    logic [63:0]              n_step, res_step;
    logic [DIV_W-1:0]         rem_step [3];
    logic [QW-1:0]            q_step [3];
    logic signed [VEC_W-1:0]  o_vec [3];
    logic signed [VEC_W-1:0]  o_abs [3];
    logic                     fin;
    logic signed [DW-1:0]     job_d [3];

    assign job_d[0] = job.dx;
    assign job_d[1] = job.dy;
    assign job_d[2] = job.dz;

    assign any_high = (mg_reg[0][MAG_W-1:31] != '0) || (mg_reg[1][MAG_W-1:31] != '0)
                   || (mg_reg[2][MAG_W-1:31] != '0);
    assign any_top  = mg_reg[0][30] || mg_reg[1][30] || mg_reg[2][30];

    assign wb_sum  = a_done_reg && (a_dest_reg == lavm_pkg::DST_SUM);
    assign wb_last = a_done_reg && (a_dest_reg == lavm_pkg::DST_T1);

    // square root digit step
    always_comb
    begin
        sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        if ({1'b0, sq_n_reg} >= sq_trial)
        begin
            n_step   = sq_n_reg - sq_trial[63:0];
            res_step = (sq_res_reg >> 1) + sq_bit_reg;
        end
        else
        begin
            n_step   = sq_n_reg;
            res_step = sq_res_reg >> 1;
        end
    end

    // divider step, three lanes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rem_reg[i] >= dsr_reg)
            begin
                rem_step[i] = rem_reg[i] - dsr_reg;
                q_step[i]   = {q_reg[i][QW-2:0], 1'b1};
            end
            else
            begin
                rem_step[i] = rem_reg[i];
                q_step[i]   = {q_reg[i][QW-2:0], 1'b0};
            end
            if (state_reg == lavm_pkg::ENG_DIV)
            begin
                o_vec[i] = sgn_reg[i] ? -signed'(VEC_W'(q_step[i]))
                                      : signed'(VEC_W'(q_step[i]));
            end
            else
            begin
                o_vec[i] = '0;
            end
            o_abs[i] = o_vec[i][VEC_W-1] ? -o_vec[i] : o_vec[i];
        end
    end

    assign fin = ((state_reg == lavm_pkg::ENG_NORM) && zero_reg)
              || ((state_reg == lavm_pkg::ENG_DIV) && (cnt_reg == '0));

    // operand selection
    always_comb
    begin
        issue    = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        op_first = 1'b0;
        op_last  = 1'b0;
        op_dest  = lavm_pkg::DST_SUM;
        if (state_reg == lavm_pkg::ENG_SQ)
        begin
            issue    = 1'b1;
            op_first = cnt_reg == '0;
            op_last  = cnt_reg == CNT_W'(SQ_OPS - 1);
            unique case (cnt_reg[1:0])
                2'd0:    mul_a = signed'(mg_reg[0]);
                2'd1:    mul_a = signed'(mg_reg[1]);
                default: mul_a = signed'(mg_reg[2]);
            endcase
            mul_b = mul_a;
        end
        else if (state_reg == lavm_pkg::ENG_MAC)
        begin
            issue = 1'b1;
            unique case (cnt_reg[3:0])
                4'd0:
                begin
                    mul_a = MUL_W'(r_reg[1]); mul_b = MUL_W'(f_reg[2]);
                    op_first = 1'b1; op_last = 1'b1; op_dest = lavm_pkg::DST_U0;
                end
                4'd1:
                begin
                    mul_a = -MUL_W'(r_reg[0]); mul_b = MUL_W'(f_reg[2]);
                    op_first = 1'b1; op_last = 1'b1; op_dest = lavm_pkg::DST_U1;
                end
                4'd2:
                begin
                    mul_a = MUL_W'(r_reg[0]); mul_b = MUL_W'(f_reg[1]);
                    op_first = 1'b1; op_dest = lavm_pkg::DST_U2;
                end
                4'd3:
                begin
                    mul_a = -MUL_W'(r_reg[1]); mul_b = MUL_W'(f_reg[0]);
                    op_last = 1'b1; op_dest = lavm_pkg::DST_U2;
                end
                4'd4:
                begin
                    mul_a = MUL_W'(r_reg[0]); mul_b = MUL_W'(eye_reg[0]);
                    op_first = 1'b1; op_dest = lavm_pkg::DST_T0;
                end
                4'd5:
                begin
                    mul_a = MUL_W'(r_reg[1]); mul_b = MUL_W'(eye_reg[1]);
                    op_last = 1'b1; op_dest = lavm_pkg::DST_T0;
                end
                4'd6:
                begin
                    mul_a = MUL_W'(f_reg[0]); mul_b = MUL_W'(eye_reg[0]);
                    op_first = 1'b1; op_dest = lavm_pkg::DST_T2;
                end
                4'd7:
                begin
                    mul_a = MUL_W'(f_reg[1]); mul_b = MUL_W'(eye_reg[1]);
                    op_dest = lavm_pkg::DST_T2;
                end
                4'd8:
                begin
                    mul_a = MUL_W'(f_reg[2]); mul_b = MUL_W'(eye_reg[2]);
                    op_last = 1'b1; op_dest = lavm_pkg::DST_T2;
                end
                4'd9:
                begin
                    mul_a = MUL_W'(u_reg[0]); mul_b = MUL_W'(eye_reg[0]);
                    op_first = 1'b1; op_dest = lavm_pkg::DST_T1;
                end
                4'd10:
                begin
                    mul_a = MUL_W'(u_reg[1]); mul_b = MUL_W'(eye_reg[1]);
                    op_dest = lavm_pkg::DST_T1;
                end
                4'd11:
                begin
                    mul_a = MUL_W'(u_reg[2]); mul_b = MUL_W'(eye_reg[2]);
                    op_last = 1'b1; op_dest = lavm_pkg::DST_T1;
                end
                default:
                begin
                    issue = 1'b0;
                end
            endcase
        end
    end

    // rounding shift and clamp of the accumulated sum
    always_comb
    begin
        acc_mag = acc_reg[ACC_W-1] ? unsigned'(-acc_reg) : unsigned'(acc_reg);
        rnd     = (acc_mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        rs      = acc_reg[ACC_W-1] ? -signed'(rnd) : signed'(rnd);
        tv      = (a_dest_reg == lavm_pkg::DST_T2) ? rs : -rs;
        clamp_hit = 1'b0;
        if (tv > ACC_W'(lavm_pkg::VAL_MAX))
        begin
            clamp_v   = lavm_pkg::VAL_MAX;
            clamp_hit = 1'b1;
        end
        else if (tv < ACC_W'(lavm_pkg::VAL_MIN))
        begin
            clamp_v   = lavm_pkg::VAL_MIN;
            clamp_hit = 1'b1;
        end
        else
        begin
            clamp_v = VW'(tv);
        end
    end

    always_comb
    begin : next_state
        state_next = state_reg;
        unique case (state_reg)
            lavm_pkg::ENG_IDLE:
                if (job_valid) state_next = lavm_pkg::ENG_NORM;
            lavm_pkg::ENG_NORM:
                if (zero_reg)
                    state_next = pass_reg ? lavm_pkg::ENG_MAC : lavm_pkg::ENG_NORM;
                else if (!any_high && any_top)
                    state_next = lavm_pkg::ENG_SQ;
            lavm_pkg::ENG_SQ:
                if (cnt_reg == CNT_W'(SQ_OPS - 1)) state_next = lavm_pkg::ENG_SQW;
            lavm_pkg::ENG_SQW:
                if (wb_sum) state_next = lavm_pkg::ENG_SQRT;
            lavm_pkg::ENG_SQRT:
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) state_next = lavm_pkg::ENG_DIV;
            lavm_pkg::ENG_DIV:
                if (cnt_reg == '0)
                    state_next = pass_reg ? lavm_pkg::ENG_MAC : lavm_pkg::ENG_NORM;
            lavm_pkg::ENG_MAC:
                if (cnt_reg == CNT_W'(MAC_OPS - 1)) state_next = lavm_pkg::ENG_MACW;
            lavm_pkg::ENG_MACW:
                if (wb_last) state_next = lavm_pkg::ENG_DONE;
            lavm_pkg::ENG_DONE:
                if (mat_ready) state_next = lavm_pkg::ENG_IDLE;
            default:
                state_next = lavm_pkg::ENG_IDLE;
        endcase
    end

    always_comb
    begin : datapath
        pass_next   = pass_reg;
        cnt_next    = cnt_reg;
        sgn_next    = sgn_reg;
        zero_next   = zero_reg;
        degen_next  = degen_reg;
        sat_next    = sat_reg;
        sq_n_next   = sq_n_reg;
        sq_res_next = sq_res_reg;
        sq_bit_next = sq_bit_reg;
        dsr_next    = dsr_reg;
        for (int i = 0; i < 3; i++)
        begin
            eye_next[i] = eye_reg[i];
            mg_next[i]  = mg_reg[i];
            f_next[i]   = f_reg[i];
            r_next[i]   = r_reg[i];
            u_next[i]   = u_reg[i];
            t_next[i]   = t_reg[i];
            rem_next[i] = rem_reg[i];
            q_next[i]   = q_reg[i];
        end

        // writeback of a finished sum
        if (a_done_reg)
        begin
            unique case (a_dest_reg)
                lavm_pkg::DST_SUM:
                begin
                    sq_n_next   = acc_reg[63:0];
                    sq_res_next = '0;
                    sq_bit_next = 64'h4000_0000_0000_0000;
                    cnt_next    = '0;
                end
                lavm_pkg::DST_U0: u_next[0] = VW'(rs);
                lavm_pkg::DST_U1: u_next[1] = VW'(rs);
                lavm_pkg::DST_U2: u_next[2] = VW'(rs);
                lavm_pkg::DST_T0:
                begin
                    t_next[0] = clamp_v;
                    sat_next  = sat_reg | clamp_hit;
                end
                lavm_pkg::DST_T1:
                begin
                    t_next[1] = clamp_v;
                    sat_next  = sat_reg | clamp_hit;
                end
                lavm_pkg::DST_T2:
                begin
                    t_next[2] = clamp_v;
                    sat_next  = sat_reg | clamp_hit;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            lavm_pkg::ENG_IDLE:
            begin
                if (job_valid)
                begin
                    pass_next  = 1'b0;
                    zero_next  = job.dzero;
                    degen_next = 1'b0;
                    sat_next   = 1'b0;
                    eye_next[0] = job.eye_x;
                    eye_next[1] = job.eye_y;
                    eye_next[2] = job.eye_z;
                    for (int i = 0; i < 3; i++)
                    begin
                        sgn_next[i] = job_d[i][DW-1];
                        mg_next[i]  = job_d[i][DW-1] ? unsigned'(-job_d[i])
                                                     : unsigned'(job_d[i]);
                    end
                end
            end
            lavm_pkg::ENG_NORM:
            begin
                if (!zero_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (any_high)
                            mg_next[i] = mg_reg[i] >> 1;
                        else if (!any_top)
                            mg_next[i] = mg_reg[i] << 1;
                    end
                    cnt_next = '0;
                end
            end
            lavm_pkg::ENG_SQ:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            lavm_pkg::ENG_SQRT:
            begin
                sq_n_next   = n_step;
                sq_res_next = res_step;
                sq_bit_next = sq_bit_reg >> 2;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    // len is the root, numerators carry half of it for rounding
                    dsr_next = DIV_W'(res_step[LEN_W-1:0]) << FRAC_BITS;
                    cnt_next = CNT_W'(FRAC_BITS);
                    for (int i = 0; i < 3; i++)
                    begin
                        rem_next[i] = (DIV_W'(mg_reg[i][30:0]) << FRAC_BITS)
                                    + DIV_W'(res_step[LEN_W-1:1]);
                        q_next[i]   = '0;
                    end
                end
            end
            lavm_pkg::ENG_DIV:
            begin
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = rem_step[i];
                    q_next[i]   = q_step[i];
                end
            end
            lavm_pkg::ENG_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            default: ;
        endcase

        // end of one normalisation
        if (fin)
        begin
            degen_next = degen_reg | zero_reg;
            if (!pass_reg)
            begin
                for (int i = 0; i < 3; i++) f_next[i] = o_vec[i];
                // right vector before normalising: (f.y, -f.x, 0)
                pass_next   = 1'b1;
                sgn_next[0] = o_vec[1][VEC_W-1];
                sgn_next[1] = (o_vec[0] > 0);
                sgn_next[2] = 1'b0;
                mg_next[0]  = MAG_W'(unsigned'(o_abs[1]));
                mg_next[1]  = MAG_W'(unsigned'(o_abs[0]));
                mg_next[2]  = '0;
                zero_next   = (o_vec[0] == '0) && (o_vec[1] == '0);
            end
            else
            begin
                for (int i = 0; i < 3; i++) r_next[i] = o_vec[i];
                cnt_next = '0;
            end
        end
    end

    assign job_pop   = (state_reg == lavm_pkg::ENG_IDLE) && job_valid;
    assign mat_valid = state_reg == lavm_pkg::ENG_DONE;

    always_comb
    begin
        mat.r0 = VW'(r_reg[0]);
        mat.r1 = VW'(r_reg[1]);
        mat.r2 = VW'(r_reg[2]);
        mat.u0 = u_reg[0];
        mat.u1 = u_reg[1];
        mat.u2 = u_reg[2];
        mat.f0 = VW'(f_reg[0]);
        mat.f1 = VW'(f_reg[1]);
        mat.f2 = VW'(f_reg[2]);
        mat.t0 = t_reg[0];
        mat.t1 = t_reg[1];
        mat.t2 = t_reg[2];
        mat.degenerate = degen_reg;
        mat.saturated  = sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lavm_pkg::ENG_IDLE;
            pass_reg   <= 1'b0;
            cnt_reg    <= '0;
            p_vld_reg  <= 1'b0;
            a_done_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            cnt_reg    <= cnt_next;
            p_vld_reg  <= issue;
            a_done_reg <= p_vld_reg && p_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sgn_reg     <= sgn_next;
        zero_reg    <= zero_next;
        degen_reg   <= degen_next;
        sat_reg     <= sat_next;
        sq_n_reg    <= sq_n_next;
        sq_res_reg  <= sq_res_next;
        sq_bit_reg  <= sq_bit_next;
        dsr_reg     <= dsr_next;
        for (int i = 0; i < 3; i++)
        begin
            eye_reg[i] <= eye_next[i];
            mg_reg[i]  <= mg_next[i];
            f_reg[i]   <= f_next[i];
            r_reg[i]   <= r_next[i];
            u_reg[i]   <= u_next[i];
            t_reg[i]   <= t_next[i];
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
        end
        prod_reg    <= ACC_W'(mul_a) * ACC_W'(mul_b);
        p_first_reg <= op_first;
        p_last_reg  <= op_last;
        p_dest_reg  <= op_dest;
        a_dest_reg  <= p_dest_reg;
        if (p_vld_reg)
        begin
            acc_reg <= (p_first_reg ? '0 : acc_reg) + prod_reg;
        end
    end

endmodule

// ----- src/lavm_out.sv -----
// lavm_out: column emitter, holds one finished matrix and sends its four columns
// takes the next matrix as the last column transfers
// depends on lavm_pkg
module lavm_out #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mat_valid,
    output logic                mat_ready,
    input  lavm_pkg::mat_t      mat,
    output logic                col_valid,
    input  logic                col_ready,
    output lavm_pkg::col_item_t col_item
);

    localparam int VW = lavm_pkg::VAL_W;
    localparam logic signed [VW-1:0] UNIT_VAL = VW'(1) << FRAC_BITS;

    lavm_pkg::mat_t                 buf_reg;
    logic                           busy_reg, busy_next;
    logic [lavm_pkg::COL_W-1:0]     col_reg, col_next;
    logic                           col_fire;
    logic                           at_last;
    logic                           load;

    assign col_valid = busy_reg;
    assign col_fire  = col_valid && col_ready;
    assign at_last   = col_reg == lavm_pkg::LAST_COL;
    assign mat_ready = !busy_reg || (col_fire && at_last);
    assign load      = mat_valid && mat_ready;

    always_comb
    begin
        busy_next = busy_reg;
        col_next  = col_reg;
        if (load)
        begin
            busy_next = 1'b1;
            col_next  = '0;
        end
        else if (col_fire)
        begin
            busy_next = !at_last;
            col_next  = col_reg + 1'b1;
        end
    end

    always_comb
    begin
        col_item.column_index = col_reg;
        col_item.last_column  = at_last;
        col_item.degenerate   = buf_reg.degenerate;
        col_item.saturated    = buf_reg.saturated;
        unique case (col_reg)
            2'd0:
            begin
                col_item.row0_value = buf_reg.r0;
                col_item.row1_value = buf_reg.u0;
                col_item.row2_value = -buf_reg.f0;
                col_item.row3_value = '0;
            end
            2'd1:
            begin
                col_item.row0_value = buf_reg.r1;
                col_item.row1_value = buf_reg.u1;
                col_item.row2_value = -buf_reg.f1;
                col_item.row3_value = '0;
            end
            2'd2:
            begin
                col_item.row0_value = buf_reg.r2;
                col_item.row1_value = buf_reg.u2;
                col_item.row2_value = -buf_reg.f2;
                col_item.row3_value = '0;
            end
            default:
            begin
                col_item.row0_value = buf_reg.t0;
                col_item.row1_value = buf_reg.t1;
                col_item.row2_value = buf_reg.t2;
                col_item.row3_value = UNIT_VAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= mat;
        end
    end

endmodule

// ----- src/look_at_view_matrix_core.sv -----
// look_at_view_matrix_core: top level of the look-at view matrix generator
// instantiates lavm_front, lavm_engine and lavm_out; depends on lavm_pkg
//
// usage
//  - cam channel (cam_valid/cam_ready/cam_item): one eye and target point per
//    transfer, signed fixed point with FRAC_BITS fraction bits
//  - col channel (col_valid/col_ready/col_item): four transfers per camera item,
//    columns 0 to 3 of the column-major view matrix, last_column on column 3
//  - the front end queues up to two classified items, so cam_ready stays high
//    while the back end works and while a finished matrix waits to go out,
//    until both entries are filled
//  - the back end takes one item at a time: two normalisations, each a one bit
//    per cycle shift, three squares, a 32 step square root and a FRAC_BITS+1
//    step divider, then twelve multiply-accumulates
//  - it takes no new item before its last matrix has gone to the column
//    emitter; a zero-length vector skips its squares, square root and divider
//  - the four columns of a matrix go out back to back while col_ready stays high
//  - a stalled receiver holds the current column; the back end finishes the
//    next matrix and waits, and the queue then fills and drops cam_ready
//  - reset empties the queue, idles the back end and drops col_valid;
//    there is no clearing pass
module look_at_view_matrix_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cam_valid,
    output logic                cam_ready,
    input  lavm_pkg::cam_item_t cam_item,
    output logic                col_valid,
    input  logic                col_ready,
    output lavm_pkg::col_item_t col_item
);

    localparam int VW = lavm_pkg::VAL_W;
    localparam logic signed [VW-1:0] UNIT_VAL = VW'(1) << FRAC_BITS;

    // queue between front and back end
    logic           job_valid;
    logic           job_pop;
    lavm_pkg::job_t job;

    // finished matrix towards the column emitter
    logic           mat_valid;
    logic           mat_ready;
    lavm_pkg::mat_t mat;

    lavm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cam_valid (cam_valid),
        .cam_ready (cam_ready),
        .cam_item  (cam_item),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    lavm_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat)
    );

    lavm_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col_item  (col_item)
    );

    // a matrix never breaks off after a non-final column
    a_cols_follow : assert property (@(posedge clk) disable iff (!rst_n)
        col_valid && col_ready && !col_item.last_column |=> col_valid)
        else $error("column sequence broke off before the last column");

    // flags are the same on all four columns of one matrix
    a_flags_held : assert property (@(posedge clk) disable iff (!rst_n)
        col_valid && col_ready && !col_item.last_column
        |=> $stable(col_item.degenerate) && $stable(col_item.saturated))
        else $error("matrix flags changed within one matrix");

    // column index advances by one within a matrix
    a_col_step : assert property (@(posedge clk) disable iff (!rst_n)
        col_valid && col_ready && !col_item.last_column
        |=> col_item.column_index == $past(col_item.column_index) + 2'd1)
        else $error("column index did not advance");

    // last column carries the homogeneous one
    a_unit_row : assert property (@(posedge clk) disable iff (!rst_n)
        col_valid && col_item.last_column |-> col_item.row3_value == UNIT_VAL)
        else $error("last column without unit in row 3");

endmodule

// ----- tb/look_at_view_matrix_core_tb.sv -----
// look_at_view_matrix_core_tb: self-checking bench for the look-at view matrix core
// drives camera items, predicts the four matrix columns per item and checks them
// depends on lavm_pkg and look_at_view_matrix_core
`timescale 1ns / 100ps

module look_at_view_matrix_core_tb;

    localparam int FRAC = 16;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD = 800;
    localparam int SETTLE_CYCLES = 400;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cam_valid = 1'b0;
    logic                cam_ready;
    lavm_pkg::cam_item_t cam_item = '0;
    logic                col_valid;
    logic                col_ready = 1'b0;
    lavm_pkg::col_item_t col_item;

    // camera items waiting to be offered and columns still owed by the core
    lavm_pkg::cam_item_t pending_cams[$];
    lavm_pkg::col_item_t owed_columns[$];

    int  mismatches = 0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    bit  tx_no_idle = 1'b0;
    bit  rx_no_idle = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_taken = 1'b0;
    int  hold_left = 0;
    longint cycle_count = 0;

    look_at_view_matrix_core #(.FRAC_BITS(FRAC)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cam_valid (cam_valid),
        .cam_ready (cam_ready),
        .cam_item  (cam_item),
        .col_valid (col_valid),
        .col_ready (col_ready),
        .col_item  (col_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // floor of the square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // drop the fraction bits of a product sum, halves away from zero
    function automatic longint frac_round(longint p);
        longint unsigned m;
        m = (p < 0) ? longint'(-p) : longint'(p);
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        return (p < 0) ? -longint'(m) : longint'(m);
    endfunction

    // unit vector with FRAC fraction bits; a zero vector comes back as it is
    function automatic bit make_unit(input longint v[3], output longint o[3]);
        longint unsigned mag[3];
        longint unsigned top;
        longint unsigned sumsq;
        longint unsigned len;
        longint unsigned q;
        top = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > top)
                top = mag[i];
        end
        if (top == 0)
        begin
            o = v;
            return 1'b0;
        end
        // bring the largest magnitude into [2^30, 2^31)
        while (top >= (64'd1 << 31))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
            top >>= 1;
        end
        while (top < (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
            top <<= 1;
        end
        sumsq = 0;
        for (int i = 0; i < 3; i++)
            sumsq += mag[i] * mag[i];
        len = int_sqrt(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FRAC) + (len >> 1)) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic longint clamp_word(longint x, inout bit sat);
        if (x > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // works out the four columns of the view matrix and queues them
    task automatic queue_view_columns(lavm_pkg::cam_item_t cam);
        longint eye[3], dir[3], fwd[3], side_raw[3], side[3], upv[3];
        longint cols[4][4];
        bit degen, sat;
        lavm_pkg::col_item_t c;
        degen = 1'b0;
        sat = 1'b0;
        eye[0] = cam.eye_x;
        eye[1] = cam.eye_y;
        eye[2] = cam.eye_z;
        dir[0] = longint'(cam.target_x) - eye[0];
        dir[1] = longint'(cam.target_y) - eye[1];
        dir[2] = longint'(cam.target_z) - eye[2];
        if (!make_unit(dir, fwd))
            degen = 1'b1;
        // forward cross world up (0,0,1)
        side_raw[0] = fwd[1];
        side_raw[1] = -fwd[0];
        side_raw[2] = 0;
        if (!make_unit(side_raw, side))
            degen = 1'b1;
        upv[0] = frac_round(side[1] * fwd[2] - side[2] * fwd[1]);
        upv[1] = frac_round(side[2] * fwd[0] - side[0] * fwd[2]);
        upv[2] = frac_round(side[0] * fwd[1] - side[1] * fwd[0]);
        for (int k = 0; k < 3; k++)
        begin
            cols[k][0] = side[k];
            cols[k][1] = upv[k];
            cols[k][2] = -fwd[k];
            cols[k][3] = 0;
        end
        cols[3][0] = clamp_word(-frac_round(side[0] * eye[0] + side[1] * eye[1]
                                            + side[2] * eye[2]), sat);
        cols[3][1] = clamp_word(-frac_round(upv[0] * eye[0] + upv[1] * eye[1]
                                            + upv[2] * eye[2]), sat);
        cols[3][2] = clamp_word(frac_round(fwd[0] * eye[0] + fwd[1] * eye[1]
                                           + fwd[2] * eye[2]), sat);
        cols[3][3] = 64'sd1 << FRAC;
        for (int k = 0; k < 4; k++)
        begin
            c.column_index = k[lavm_pkg::COL_W-1:0];
            c.row0_value   = cols[k][0][lavm_pkg::VAL_W-1:0];
            c.row1_value   = cols[k][1][lavm_pkg::VAL_W-1:0];
            c.row2_value   = cols[k][2][lavm_pkg::VAL_W-1:0];
            c.row3_value   = cols[k][3][lavm_pkg::VAL_W-1:0];
            c.last_column  = (k[lavm_pkg::COL_W-1:0] == lavm_pkg::LAST_COL);
            c.degenerate   = degen;
            c.saturated    = sat;
            owed_columns.push_back(c);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers pending camera items, with a random idle gap after each item
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_valid <= 1'b0;
            cam_item  <= '0;
            tx_gap    <= 0;
        end
        else
        begin
            if (cam_valid && cam_ready)
                queue_view_columns(cam_item);
            // the slot is free once the current item has gone or none is offered
            if (!cam_valid || cam_ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap    <= tx_gap - 1;
                    cam_valid <= 1'b0;
                end
                else if (pending_cams.size() > 0)
                begin
                    cam_item  <= pending_cams.pop_front();
                    cam_valid <= 1'b1;
                    tx_gap    <= tx_no_idle ? 0 : $urandom_range(0, 3);
                end
                else
                    cam_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // long hold-off of the receiver, counted in cycles
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_request && !hold_taken)
        begin
            // queue in the core fills and cam_ready drops
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
        end
    end

    // ------------------------------------------------------------------
    // monitor: random stalls per column, ready held low during the hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_ready  <= 1'b0;
            rx_wait    <= 0;
        end
        else
        begin
            if (col_valid && col_ready)
            begin
                if (owed_columns.size() == 0)
                begin
                    $error("column transfer with nothing expected: column %0d",
                           col_item.column_index);
                    mismatches++;
                end
                else
                begin
                    lavm_pkg::col_item_t exp_col;
                    exp_col = owed_columns.pop_front();
                    if (col_item.column_index !== exp_col.column_index)
                    begin
                        $error("column_index expected %0d got %0d",
                               exp_col.column_index, col_item.column_index);
                        mismatches++;
                    end
                    if (col_item.row0_value !== exp_col.row0_value)
                    begin
                        $error("row0_value expected %0d got %0d",
                               exp_col.row0_value, col_item.row0_value);
                        mismatches++;
                    end
                    if (col_item.row1_value !== exp_col.row1_value)
                    begin
                        $error("row1_value expected %0d got %0d",
                               exp_col.row1_value, col_item.row1_value);
                        mismatches++;
                    end
                    if (col_item.row2_value !== exp_col.row2_value)
                    begin
                        $error("row2_value expected %0d got %0d",
                               exp_col.row2_value, col_item.row2_value);
                        mismatches++;
                    end
                    if (col_item.row3_value !== exp_col.row3_value)
                    begin
                        $error("row3_value expected %0d got %0d",
                               exp_col.row3_value, col_item.row3_value);
                        mismatches++;
                    end
                    if (col_item.last_column !== exp_col.last_column)
                    begin
                        $error("last_column expected %0b got %0b",
                               exp_col.last_column, col_item.last_column);
                        mismatches++;
                    end
                    if (col_item.degenerate !== exp_col.degenerate)
                    begin
                        $error("degenerate expected %0b got %0b",
                               exp_col.degenerate, col_item.degenerate);
                        mismatches++;
                    end
                    if (col_item.saturated !== exp_col.saturated)
                    begin
                        $error("saturated expected %0b got %0b",
                               exp_col.saturated, col_item.saturated);
                        mismatches++;
                    end
                end
            end

            if (hold_left > 0 || (hold_request && !hold_taken))
                col_ready <= 1'b0;
            else if (col_valid && col_ready)
            begin
                int draw;
                draw = rx_no_idle ? 0 : $urandom_range(0, 3);
                rx_wait   <= (draw > 0) ? draw - 1 : 0;
                col_ready <= (draw == 0);
            end
            else if (rx_wait > 0)
            begin
                rx_wait   <= rx_wait - 1;
                col_ready <= 1'b0;
            end
            else
                col_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL look_at_view_matrix_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic lavm_pkg::cam_item_t cam_of(int ex, int ey, int ez,
                                                   int tx, int ty, int tz);
        lavm_pkg::cam_item_t c;
        c.eye_x = ex;
        c.eye_y = ey;
        c.eye_z = ez;
        c.target_x = tx;
        c.target_y = ty;
        c.target_z = tz;
        return c;
    endfunction

    // mostly well-formed scenes, some full-range noise and degenerate cases
    function automatic lavm_pkg::cam_item_t random_cam();
        lavm_pkg::cam_item_t c;
        int span;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end
            2:
            begin
                // eye on target
                c = {$urandom, $urandom, $urandom, 96'd0};
                c.target_x = c.eye_x;
                c.target_y = c.eye_y;
                c.target_z = c.eye_z;
            end
            3:
            begin
                // looking straight up or down
                c = {$urandom, $urandom, $urandom, 96'd0};
                c.target_x = c.eye_x;
                c.target_y = c.eye_y;
                c.target_z = $urandom;
            end
            4:
            begin
                // large eye position, translation likely clamps
                c.eye_x = $urandom_range(0, 1) ? 32'sh7fff_0000 + $urandom_range(0, 65535)
                                               : 32'sh8000_0000 + $urandom_range(0, 65535);
                c.eye_y = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
                c.eye_z = $urandom;
                c.target_x = $urandom_range(0, 1048575) - 524288;
                c.target_y = $urandom_range(0, 1048575) - 524288;
                c.target_z = $urandom_range(0, 1048575) - 524288;
            end
            default:
            begin
                // ordinary scene within at most 1024 units of the origin
                span = 1 << $urandom_range(4, 26);
                c.eye_x = $urandom_range(0, 2 * span) - span;
                c.eye_y = $urandom_range(0, 2 * span) - span;
                c.eye_z = $urandom_range(0, 2 * span) - span;
                c.target_x = $urandom_range(0, 2 * span) - span;
                c.target_y = $urandom_range(0, 2 * span) - span;
                c.target_z = $urandom_range(0, 2 * span) - span;
            end
        endcase
        return c;
    endfunction

    initial
    begin
        // directed part: extremes, degenerate views, saturation, single lsb steps
        pending_cams.push_back(cam_of(0, 0, 0, 0, 0, 0));
        pending_cams.push_back(cam_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_cams.push_back(cam_of(32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000, 32'h80000000));
        pending_cams.push_back(cam_of(0, 0, 0, 0, 0, 32'h00010000));
        pending_cams.push_back(cam_of(5 << 16, -3 << 16, 32'h7fffffff,
                                      5 << 16, -3 << 16, 32'h80000000));
        pending_cams.push_back(cam_of(0, 0, 0, 1, 0, 0));
        pending_cams.push_back(cam_of(0, 0, 0, 0, -1, 0));
        pending_cams.push_back(cam_of(0, 0, 0, 1, 1, 1));
        pending_cams.push_back(cam_of(32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_cams.push_back(cam_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000, 32'h80000000, 32'h80000000));
        pending_cams.push_back(cam_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0));
        pending_cams.push_back(cam_of(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
        pending_cams.push_back(cam_of(32'h7fffffff, 0, 0, 32'h80000000, 0, 0));
        pending_cams.push_back(cam_of(0, 32'h80000000, 0, 0, 32'h7fffffff, 0));
        pending_cams.push_back(cam_of(3 << 16, 4 << 16, 2 << 16, 0, 0, 0));
        pending_cams.push_back(cam_of(0, 0, 10 << 16, 0, 0, 0));
        pending_cams.push_back(cam_of(-1, -1, -1, 0, 0, 0));
        pending_cams.push_back(cam_of(32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
                                      32'hf0f0f0f0, 32'h55555555, 32'haaaaaaaa));
        pending_cams.push_back(cam_of(32'h7fffffff, 32'h80000000, 0,
                                      32'h80000000, 32'h7fffffff, 1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_cams.push_back(random_cam());

        // back-to-back stretch, then the long hold-off, then random idling
        wait (pending_cams.size() < RANDOM_ITEMS - 40);
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        wait (pending_cams.size() < RANDOM_ITEMS - 80);
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        hold_request = 1'b1;

        wait (pending_cams.size() == 0);
        @(posedge clk);
        while (cam_valid)
            @(posedge clk);
        while (owed_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS look_at_view_matrix_core");
        else
            $display("FAIL look_at_view_matrix_core");
        $finish;
    end

endmodule
